// File: rtl/cdma_pkg.sv
`default_nettype none
package cdma_pkg;

  localparam int NUM_CHANNELS = 7;
  localparam int CH_IDX_W     = 3;
  localparam int RAM_BYTES    = 2097152;

  localparam int OP_W       = 3;
  localparam int ADDR_W     = 8;
  localparam int DATA_W     = 32;
  localparam int MEM_ADDR_W = 21;
  localparam int MEM_DATA_W = 24;
  localparam int BASE_W     = 24;
  localparam int CNT_W      = 16;
  localparam int LEFT_W     = 17;

  localparam logic [OP_W-1:0] OP_CH_WR   = 3'd0;
  localparam logic [OP_W-1:0] OP_CH_RD   = 3'd1;
  localparam logic [OP_W-1:0] OP_CTRL_WR = 3'd2;
  localparam logic [OP_W-1:0] OP_CTRL_RD = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  localparam logic [3:0] OFF_BASE = 4'h0;
  localparam logic [3:0] OFF_BCR  = 4'h4;
  localparam logic [3:0] OFF_CHCR = 4'h8;

  localparam logic [1:0] SYNC_WORDS = 2'd0;
  localparam logic [1:0] SYNC_BLOCK = 2'd1;

  localparam logic [CH_IDX_W-1:0] CH_INSTANT = 3'd2;
  localparam logic [CH_IDX_W-1:0] CH_OTC     = 3'd6;

  localparam logic [MEM_DATA_W-1:0] LIST_END   = 24'hFFFFFF;
  localparam logic [BASE_W-1:0]     RAM_MASK   = BASE_W'(RAM_BYTES - 1);
  localparam logic [LEFT_W-1:0]     FULL_COUNT = 17'h10000;

  typedef struct packed {
    logic accept;
    logic access;
    logic list_tick;
    logic busy_nxt;
  } cdma_cmd_t;

  typedef struct packed {
    logic list_start;
    logic list_last;
  } cdma_sts_t;

endpackage
`default_nettype wire

// File: rtl/cdma_if.sv
`default_nettype none
interface cdma_in_if
  import cdma_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ADDR_W-1:0]   reg_addr;
  logic [DATA_W-1:0]   wdata;

  modport source (output valid, op, reg_addr, wdata, input ready);
  modport sink   (input valid, op, reg_addr, wdata, output ready);
endinterface

interface cdma_out_if
  import cdma_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [DATA_W-1:0]     rdata;
  logic                  mem_we;
  logic [MEM_ADDR_W-1:0] mem_addr;
  logic [MEM_DATA_W-1:0] mem_data;
  logic                  irq;
  logic                  busy_res;

  modport source (output valid, rdata, mem_we, mem_addr, mem_data, irq, busy_res,
                  input ready);
  modport sink   (input valid, rdata, mem_we, mem_addr, mem_data, irq, busy_res,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/cdma_ctrl.sv
`default_nettype none
module cdma_ctrl
  import cdma_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_op,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire cdma_sts_t       sts,
  output cdma_cmd_t            cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic is_tick;

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign is_tick   = (in_op == OP_TICK);

  always_comb begin
    cmd.accept    = accept;
    cmd.access    = 1'b0;
    cmd.list_tick = 1'b0;
    state_nxt     = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.access = accept && !is_tick;
        if (cmd.access && sts.list_start) begin
          state_nxt = ST_LIST;
        end
      end
      ST_LIST: begin
        cmd.list_tick = accept && is_tick;
        if (cmd.list_tick && sts.list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.busy_nxt = (state_nxt == ST_LIST);
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cdma_dp.sv
`default_nettype none
module cdma_dp
  import cdma_pkg::*;
#(
  parameter int RAM_BYTES = cdma_pkg::RAM_BYTES
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cdma_cmd_t             cmd,
  output cdma_sts_t                  sts,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [ADDR_W-1:0]     in_reg_addr,
  input  wire logic [DATA_W-1:0]     in_wdata,
  output logic [DATA_W-1:0]          out_rdata,
  output logic                       out_mem_we,
  output logic [MEM_ADDR_W-1:0]      out_mem_addr,
  output logic [MEM_DATA_W-1:0]      out_mem_data,
  output logic                       out_irq,
  output logic                       out_busy_res
);

  localparam logic [BASE_W-1:0] ADDR_MASK = BASE_W'(RAM_BYTES - 1);

  logic [NUM_CHANNELS-1:0] en_r;
  logic [DATA_W-1:0]       ctrl_word_r;
  logic [BASE_W-1:0]       base_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]        bamt_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]        bsize_r [NUM_CHANNELS];
  logic [CNT_W-1:0]        wcnt_r  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] dir_r;
  logic [NUM_CHANNELS-1:0] step_r;
  logic [1:0]              sync_r  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] start_r;
  logic [NUM_CHANNELS-1:0] trig_r;
  logic [LEFT_W-1:0]       words_left_r;

  logic [DATA_W-1:0]       rdata_r;
  logic                    mem_we_r;
  logic [MEM_ADDR_W-1:0]   mem_addr_r;
  logic [MEM_DATA_W-1:0]   mem_data_r;
  logic                    irq_r;
  logic                    busy_r;

  logic [CH_IDX_W-1:0]     ch;
  logic [3:0]              off;
  logic                    ch_ok;
  logic                    chcr_wr;
  logic                    fire;
  logic [BASE_W-1:0]       otc_base;
  logic [BASE_W-1:0]       otc_prev;
  logic [DATA_W-1:0]       rdata_c;
  logic [DATA_W-1:0]       ch_rd;

  assign ch       = in_reg_addr[6:4];
  assign off      = in_reg_addr[3:0];
  assign ch_ok    = in_reg_addr[7] && (32'(ch) < NUM_CHANNELS);
  assign chcr_wr  = (in_op == OP_CH_WR) && ch_ok && (off == OFF_CHCR);
  assign fire     = chcr_wr && en_r[ch] && in_wdata[24]
                    && ((ch == CH_INSTANT) || (ch == CH_OTC));
  assign otc_base = base_r[CH_OTC];
  assign otc_prev = otc_base - BASE_W'(4);

  assign sts.list_start = chcr_wr && (ch == CH_OTC) && en_r[CH_OTC] && in_wdata[24];
  assign sts.list_last  = (words_left_r <= LEFT_W'(1));

  always_comb begin
    ch_rd = '0;
    if (ch_ok) begin
      unique case (off)
        OFF_BASE: ch_rd = {8'd0, base_r[ch]};
        OFF_BCR: begin
          if (sync_r[ch] == SYNC_WORDS) begin
            ch_rd = {16'd0, wcnt_r[ch]};
          end else if (sync_r[ch] == SYNC_BLOCK) begin
            ch_rd = {bamt_r[ch], bsize_r[ch]};
          end
        end
        OFF_CHCR: ch_rd = {3'd0, trig_r[ch], 3'd0, start_r[ch], 13'd0, sync_r[ch],
                           7'd0, step_r[ch], dir_r[ch]};
        default: ch_rd = '0;
      endcase
    end
  end

  always_comb begin
    rdata_c = '0;
    if (cmd.access) begin
      if (in_op == OP_CH_RD) begin
        rdata_c = ch_rd;
      end else if (in_op == OP_CTRL_RD) begin
        rdata_c = ctrl_word_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= '0;
      ctrl_word_r  <= '0;
      dir_r        <= '0;
      step_r       <= '0;
      start_r      <= '0;
      trig_r       <= '0;
      words_left_r <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        base_r[k]  <= '0;
        bamt_r[k]  <= '0;
        bsize_r[k] <= '0;
        wcnt_r[k]  <= '0;
        sync_r[k]  <= '0;
      end
    end else begin
      if (cmd.list_tick) begin
        base_r[CH_OTC] <= otc_prev;
        wcnt_r[CH_OTC] <= wcnt_r[CH_OTC] - CNT_W'(1);
        words_left_r   <= sts.list_last ? '0 : words_left_r - LEFT_W'(1);
      end
      if (cmd.access) begin
        unique case (in_op)
          OP_CH_WR: begin
            if (ch_ok) begin
              unique case (off)
                OFF_BASE: base_r[ch] <= in_wdata[BASE_W-1:0];
                OFF_BCR: begin
                  bamt_r[ch]  <= in_wdata[31:16];
                  bsize_r[ch] <= in_wdata[15:0];
                  wcnt_r[ch]  <= in_wdata[15:0];
                end
                OFF_CHCR: begin
                  dir_r[ch]   <= in_wdata[0];
                  step_r[ch]  <= in_wdata[1];
                  sync_r[ch]  <= in_wdata[10:9];
                  start_r[ch] <= in_wdata[24] && !fire;
                  trig_r[ch]  <= in_wdata[28] && !fire;
                  if (sts.list_start) begin
                    words_left_r <= (wcnt_r[CH_OTC] == '0) ? FULL_COUNT
                                                           : {1'b0, wcnt_r[CH_OTC]};
                  end
                end
                default: ;
              endcase
            end
          end
          OP_CTRL_WR: begin
            ctrl_word_r <= in_wdata;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
              en_r[k] <= in_wdata[3 + 4 * k];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata_r    <= rdata_c;
      mem_we_r   <= cmd.list_tick;
      mem_addr_r <= cmd.list_tick ? MEM_ADDR_W'(otc_base & ADDR_MASK & ~BASE_W'(3)) : '0;
      mem_data_r <= !cmd.list_tick ? '0 : (sts.list_last ? LIST_END : otc_prev);
      irq_r      <= cmd.access && fire;
      busy_r     <= cmd.busy_nxt;
    end
  end

  assign out_rdata    = rdata_r;
  assign out_mem_we   = mem_we_r;
  assign out_mem_addr = mem_addr_r;
  assign out_mem_data = mem_data_r;
  assign out_irq      = irq_r;
  assign out_busy_res = busy_r;

endmodule
`default_nettype wire

// File: rtl/console_dma_channel_registers.sv
// Seven-channel DMA register block with an ordering-table list builder.
// Every bus item arrives as one beat on in_ch: a channel register write or
// read, a control register write or read, or a tick. Every accepted beat
// gives exactly one result beat on out_ch, carrying read data, the list
// word written to RAM on that tick, the interrupt pulse and the busy flag.
// The result appears in the output register on the cycle after acceptance.
// Throughput is one item per cycle while the receiver keeps up; each item
// is decoded and applied to the register file in the cycle it is accepted.
// While a channel 6 list build runs, each tick writes one descending word,
// and any other item is answered with only busy_res set.
// When the receiver stalls, the result holds in the output register and
// in_ch.ready drops until that beat is taken; a new item is accepted in
// the same cycle the waiting result leaves.
// Reset clears all channel registers, the enables, the control word, any
// running list build and the output valid flag.
`default_nettype none
module console_dma_channel_registers
  import cdma_pkg::*;
#(
  parameter int RAM_BYTES = cdma_pkg::RAM_BYTES
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  cdma_in_if.sink   in_ch,
  cdma_out_if.source out_ch
);

  cdma_cmd_t cmd;
  cdma_sts_t sts;

  cdma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdma_dp #(
    .RAM_BYTES (RAM_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_ch.op),
    .in_reg_addr  (in_ch.reg_addr),
    .in_wdata     (in_ch.wdata),
    .out_rdata    (out_ch.rdata),
    .out_mem_we   (out_ch.mem_we),
    .out_mem_addr (out_ch.mem_addr),
    .out_mem_data (out_ch.mem_data),
    .out_irq      (out_ch.irq),
    .out_busy_res (out_ch.busy_res)
  );

endmodule
`default_nettype wire

// File: rtl/cdma_chk.sv
`default_nettype none
module cdma_chk
  import cdma_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_W-1:0]     out_rdata,
  input wire logic                  out_mem_we,
  input wire logic [MEM_ADDR_W-1:0] out_mem_addr,
  input wire logic [MEM_DATA_W-1:0] out_mem_data,
  input wire logic                  out_irq,
  input wire logic                  out_busy_res
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rdata) && $stable(out_mem_data))
    else $error("result beat changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without a waiting result");

  a_list_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_we |-> out_rdata == '0 && !out_irq)
    else $error("list word beat carries read data or interrupt");

  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mem_we |-> out_mem_addr == '0 && out_mem_data == '0)
    else $error("memory fields set without a list write");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_we && !out_busy_res |-> out_mem_data == LIST_END)
    else $error("list build ended without the terminator word");

endmodule

bind console_dma_channel_registers cdma_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_rdata    (out_ch.rdata),
  .out_mem_we   (out_ch.mem_we),
  .out_mem_addr (out_ch.mem_addr),
  .out_mem_data (out_ch.mem_data),
  .out_irq      (out_ch.irq),
  .out_busy_res (out_ch.busy_res)
);
`default_nettype wire
